// ===== rtl/core/ufd_pkg.sv =====
// Shared types and constants for the UART frame deframer.
// Depends on nothing; every other file of the block but ufd_stream_if uses it by scoped names.
package ufd_pkg;

	// Default frame buffer depth; frame positions wrap at this value.
	localparam int BUFFER_DEPTH = 256;
	// Entries in the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] BYTE_HEADER = 8'hFF;
	localparam logic [7:0] BYTE_STUFF  = 8'h55;
	// Position of the length byte plus one: the length is captured here.
	localparam logic [7:0] LEN_CAPTURE_POS = 8'h04;
	// First position at which stuffing is recognized.
	localparam logic [7:0] STUFF_MIN_POS = 8'h04;
	// Header and length bytes ahead of the payload.
	localparam logic [8:0] FRAME_OVERHEAD = 9'd4;

	typedef enum logic {
		FUNC_BYTE    = 1'b0,
		FUNC_RELEASE = 1'b1
	} func_t;

	typedef struct packed {
		logic [0:0] func;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] position;
		logic [0:0] kept;
		logic [0:0] restart;
		logic [0:0] frame_done;
		logic [7:0] payload_len;
		logic [0:0] held_drop;
	} out_item_t;

	// One classified beat as held in the queue.
	typedef struct packed {
		logic       release_cmd;
		logic [7:0] rx_byte;
		logic       is_header;
		logic       is_stuff;
	} entry_t;

	// Queue head as seen by the back.
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

endpackage

// ===== rtl/core/ufd_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload type is set where the channel is instantiated.
interface ufd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/uart_frame_deframer.sv =====
// UART frame deframer, top level.
// Depends on ufd_pkg, ufd_stream_if, ufd_front and ufd_back.
//
// Usage:
//   byte_chan   sink of in_item_t beats: func selects a received byte or a
//               release of a completed frame; rx_byte is the serial byte.
//   result_chan source of out_item_t beats, exactly one per input beat, in
//               order: the byte echoed, its frame position, kept/restart/
//               frame_done/held_drop flags and the captured length.
// Path: a beat accepted on byte_chan is written into the front queue, then
//   popped by the back into the result register that drives result_chan.
// Throughput: one beat per cycle sustained while result_chan.ready is high;
//   the back's frame-state update is a combinational compare and increment,
//   so it retires one queued beat every cycle the result register can take it.
// Stall: when result_chan.ready is low the result register holds its beat;
//   the back stops popping, and the two-entry front queue keeps taking beats
//   until it fills, then drops byte_chan.ready.
// Reset: arst_n clears the queue, the result valid and all frame state
//   (position, header count, length, last kept byte, held flag) at once;
//   the block takes beats as soon as reset is released.
module uart_frame_deframer #(
	parameter int BUFFER_DEPTH = ufd_pkg::BUFFER_DEPTH
) (
	input logic          clk,
	input logic          arst_n,
	ufd_stream_if.sink   byte_chan,
	ufd_stream_if.source result_chan
);
	ufd_pkg::head_t     head;
	logic               pop;
	ufd_pkg::in_item_t  in_item;
	ufd_pkg::out_item_t out_item;

	// Unpack the channel payload into the typed beat.
	assign in_item.func    = byte_chan.payload.func;
	assign in_item.rx_byte = byte_chan.payload.rx_byte;

	// Front: classify and queue incoming beats.
	ufd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_chan.valid),
		.in_ready (byte_chan.ready),
		.in_item  (in_item),
		.head     (head),
		.pop      (pop)
	);

	// Back: advance frame state and register one result per beat.
	ufd_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (result_chan.valid),
		.out_ready (result_chan.ready),
		.out_item  (out_item)
	);

	assign result_chan.payload = out_item;
endmodule

// ===== rtl/core/ufd_front.sv =====
// Front of the deframer: accepts beats, classifies them, queues them.
// Depends on ufd_pkg.
module ufd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ufd_pkg::in_item_t  in_item,
	output ufd_pkg::head_t     head,
	input  logic               pop
);
	localparam int PTR_W = (ufd_pkg::QUEUE_DEPTH > 1) ? $clog2(ufd_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(ufd_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ufd_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ufd_pkg::QUEUE_DEPTH);

	ufd_pkg::entry_t   mem_q [ufd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	ufd_pkg::entry_t   entry_new;
	logic              push, do_pop;

	always_comb begin
		entry_new.release_cmd = (in_item.func == ufd_pkg::FUNC_RELEASE);
		entry_new.rx_byte     = in_item.rx_byte;
		entry_new.is_header   = (in_item.rx_byte == ufd_pkg::BYTE_HEADER);
		entry_new.is_stuff    = (in_item.rx_byte == ufd_pkg::BYTE_STUFF);
	end

	assign in_ready   = (count_q != FULL_CNT);
	assign push       = in_valid && in_ready;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ===== rtl/core/ufd_back.sv =====
// Back of the deframer: frame state update and registered result beat.
// Depends on ufd_pkg.
module ufd_back #(
	parameter int BUFFER_DEPTH = ufd_pkg::BUFFER_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ufd_pkg::head_t     head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output ufd_pkg::out_item_t out_item
);
	localparam logic [8:0] POS_LIMIT = 9'(BUFFER_DEPTH);

	logic [7:0] write_pos_q, frame_len_q, last_kept_q;
	logic [1:0] header_run_q;
	logic       frame_held_q;
	logic       out_valid_q;
	ufd_pkg::out_item_t result_q;

	logic [7:0] wp_n, fl_n, lk_n, pos, pos_out;
	logic [1:0] hr_n, hr_inc;
	logic       held_n, kept, restart, done, held_drop, stuff;
	logic [8:0] pos_inc;
	logic       fire;

	assign fire      = head.valid && (!out_valid_q || out_ready);
	assign pop       = fire;
	assign out_valid = out_valid_q;
	assign out_item  = result_q;

	always_comb begin
		wp_n      = write_pos_q;
		fl_n      = frame_len_q;
		lk_n      = last_kept_q;
		hr_n      = header_run_q;
		held_n    = frame_held_q;
		kept      = 1'b0;
		restart   = 1'b0;
		done      = 1'b0;
		held_drop = 1'b0;
		stuff     = 1'b0;
		pos       = write_pos_q;
		pos_out   = write_pos_q;
		hr_inc    = header_run_q + 2'd1;
		pos_inc   = '0;
		if (head.entry.release_cmd) begin
			held_n  = 1'b0;
			wp_n    = '0;
			pos_out = '0;
		end else if (frame_held_q) begin
			held_drop = 1'b1;
		end else begin
			hr_n = head.entry.is_header ? hr_inc : 2'd0;
			if (hr_n == 2'd2) begin
				// Double header: restart with position 1 holding the second 0xFF.
				hr_n    = 2'd0;
				restart = 1'b1;
				pos     = 8'd1;
			end
			pos_out = pos;
			stuff   = !restart && (pos >= ufd_pkg::STUFF_MIN_POS) && head.entry.is_stuff
				&& (last_kept_q == ufd_pkg::BYTE_HEADER);
			if (!stuff) begin
				kept    = 1'b1;
				lk_n    = restart ? ufd_pkg::BYTE_HEADER : head.entry.rx_byte;
				pos_inc = {1'b0, pos} + 9'd1;
				pos     = (pos_inc >= POS_LIMIT) ? 8'd0 : pos_inc[7:0];
			end
			wp_n = pos;
			if (wp_n == ufd_pkg::LEN_CAPTURE_POS) begin
				fl_n = lk_n;
			end
			if ({1'b0, wp_n} == ({1'b0, fl_n} + ufd_pkg::FRAME_OVERHEAD)) begin
				held_n = 1'b1;
				done   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q  <= '0;
			frame_len_q  <= '0;
			last_kept_q  <= '0;
			header_run_q <= '0;
			frame_held_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				write_pos_q  <= wp_n;
				frame_len_q  <= fl_n;
				last_kept_q  <= lk_n;
				header_run_q <= hr_n;
				frame_held_q <= held_n;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.data_byte   <= head.entry.rx_byte;
			result_q.position    <= pos_out;
			result_q.kept        <= kept;
			result_q.restart     <= restart;
			result_q.frame_done  <= done;
			result_q.payload_len <= fl_n;
			result_q.held_drop   <= held_drop;
		end
	end
endmodule

// ===== tb/ufd_frame_check.sv =====
`timescale 1ns / 100ps
// Frame tracker and result comparator for the UART frame deframer testbench.
// Depends on ufd_pkg; watches both channels of the block and counts mismatches.
module ufd_frame_check #(
	parameter int BUFFER_DEPTH = ufd_pkg::BUFFER_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               byte_ready,
	input  ufd_pkg::in_item_t  byte_beat,
	input  logic               res_valid,
	input  logic               res_ready,
	input  ufd_pkg::out_item_t res_beat,
	output int                 fail_count,
	output int                 pending
);

	// Expected result beats, oldest first.
	ufd_pkg::out_item_t want_q[$];
	int                 res_no;

	// Tracked frame state.
	logic [7:0] pos_r;
	logic [1:0] hdr_r;
	logic [7:0] len_r;
	logic [7:0] last_r;
	logic       held_r;

	task automatic report(input string msg);
		$display("%0t: result %0d: %s", $time, res_no, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// Advance the tracked frame by one input beat and build its result.
	task automatic track_beat(input ufd_pkg::in_item_t it, output ufd_pkg::out_item_t r);
		logic [8:0] p;
		logic [7:0] b;
		logic [7:0] stored;
		logic [7:0] prev;
		logic       keep;
		b = it.rx_byte;
		r = '0;
		r.data_byte = b;
		r.position = pos_r;
		if (it.func == ufd_pkg::FUNC_RELEASE) begin
			held_r = 1'b0;
			pos_r = 8'd0;
			r.position = 8'd0;
		end else if (held_r) begin
			r.held_drop = 1'b1;
		end else begin
			p = {1'b0, pos_r};
			stored = b;
			prev = last_r;
			hdr_r = (b == ufd_pkg::BYTE_HEADER) ? hdr_r + 2'd1 : 2'd0;
			if (hdr_r == 2'd2) begin
				// double header: restart with position 1 holding the header byte
				hdr_r = 2'd0;
				r.restart = 1'b1;
				p = 9'd1;
				prev = ufd_pkg::BYTE_HEADER;
				stored = ufd_pkg::BYTE_HEADER;
			end
			r.position = p[7:0];
			keep = !(p >= {1'b0, ufd_pkg::STUFF_MIN_POS} && stored == ufd_pkg::BYTE_STUFF
				&& prev == ufd_pkg::BYTE_HEADER);
			if (keep) begin
				last_r = stored;
				p = p + 9'd1;
				if (p >= BUFFER_DEPTH)
					p = 9'd0;
			end
			r.kept = keep;
			pos_r = p[7:0];
			if (pos_r == ufd_pkg::LEN_CAPTURE_POS)
				len_r = last_r;
			if ({1'b0, pos_r} == {1'b0, len_r} + ufd_pkg::FRAME_OVERHEAD) begin
				held_r = 1'b1;
				r.frame_done = 1'b1;
			end
		end
		r.payload_len = len_r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		ufd_pkg::out_item_t w;
		if (!arst_n) begin
			want_q.delete();
			pos_r = '0;
			hdr_r = '0;
			len_r = '0;
			last_r = '0;
			held_r = 1'b0;
			res_no = 0;
			fail_count = 0;
			pending <= 0;
		end else begin
			// Compare first: a result never belongs to a beat taken at this edge.
			if (res_valid && res_ready) begin
				if (want_q.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					w = want_q.pop_front();
					check_field("data_byte", int'(res_beat.data_byte), int'(w.data_byte));
					check_field("position", int'(res_beat.position), int'(w.position));
					check_field("kept", int'(res_beat.kept), int'(w.kept));
					check_field("restart", int'(res_beat.restart), int'(w.restart));
					check_field("frame_done", int'(res_beat.frame_done),
						int'(w.frame_done));
					check_field("payload_len", int'(res_beat.payload_len),
						int'(w.payload_len));
					check_field("held_drop", int'(res_beat.held_drop), int'(w.held_drop));
				end
				res_no++;
			end
			if (byte_valid && byte_ready) begin
				track_beat(byte_beat, w);
				want_q.push_back(w);
			end
			pending <= want_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the UART frame deframer testbench: clock, reset, stimulus and verdict.
// Depends on ufd_pkg, ufd_stream_if, uart_frame_deframer and ufd_frame_check.
module tb;

	// Stop offering new random work once this many non-trailing beats went in.
	localparam int ITEMS = 450;
	// Receiver hold-off while the sender keeps offering: fills the block.
	localparam int HOLD_CYCLES = 150;
	// Cycles without any beat on either channel before the run is declared hung.
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ufd_stream_if #(.payload_t(ufd_pkg::in_item_t))  byte_chan ();
	ufd_stream_if #(.payload_t(ufd_pkg::out_item_t)) result_chan ();

	int fail_count;
	int pending;

	// Beats accepted so far, and how many of them were trailing bytes after a frame.
	int beats_sent;
	int tail_sent;
	// Sender runs without gaps while set.
	bit gapless;
	// Raised by the stimulus to ask the receiver for one long hold-off.
	bit burst_mode;

	uart_frame_deframer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_chan   (byte_chan),
		.result_chan (result_chan)
	);

	ufd_frame_check frame_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_chan.valid),
		.byte_ready (byte_chan.ready),
		.byte_beat  (byte_chan.payload),
		.res_valid  (result_chan.valid),
		.res_ready  (result_chan.ready),
		.res_beat   (result_chan.payload),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Gap length in cycles: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Payload byte, biased toward the header and stuffing values.
	function automatic logic [7:0] body_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return ufd_pkg::BYTE_HEADER;
		if (r < 25)
			return ufd_pkg::BYTE_STUFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one beat and hold it until taken. Keep valid high when no gap
	// follows, so back-to-back beats never toggle valid within one edge.
	task automatic send_beat(input ufd_pkg::func_t f, input logic [7:0] b);
		ufd_pkg::in_item_t it;
		int                gap;
		it.func = f;
		it.rx_byte = b;
		byte_chan.payload <= it;
		byte_chan.valid <= 1'b1;
		@(posedge clk);
		while (!byte_chan.ready)
			@(posedge clk);
		beats_sent++;
		gap = (gapless || burst_mode) ? 0 : pick_gap();
		if (gap > 0) begin
			byte_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_release();
		send_beat(ufd_pkg::FUNC_RELEASE, 8'($urandom_range(0, 255)));
	endtask

	// Send n payload bytes; stuff a header byte with the given percentage.
	task automatic send_body(input int n, input int stuff_pct);
		logic [7:0] b;
		repeat (n) begin
			b = body_byte();
			send_beat(ufd_pkg::FUNC_BYTE, b);
			if (b == ufd_pkg::BYTE_HEADER && $urandom_range(0, 99) < stuff_pct)
				send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_STUFF);
		end
	endtask

	task automatic send_frame(input logic [7:0] len, input int body_len);
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_BYTE, len);
		send_body(body_len, 85);
	endtask

	// Drop valid and wait until every expected result beat has come back.
	task automatic drain();
		byte_chan.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// One random unit of traffic: mostly well-formed frames, the rest noise.
	task automatic random_unit();
		int         pick;
		int         n;
		logic [7:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 68) begin
			len = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(9, 40))
				: 8'($urandom_range(0, 8));
			send_frame(len, len);
			// trailing bytes, dropped only if the frame has already completed
			n = $urandom_range(0, 2);
			repeat (n) begin
				send_beat(ufd_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)));
				tail_sent++;
			end
			if ($urandom_range(0, 99) < 92)
				send_release();
		end else if (pick < 80) begin
			repeat ($urandom_range(1, 8)) send_beat(ufd_pkg::FUNC_BYTE, body_byte());
		end else if (pick < 90) begin
			// truncated frame: the next header restarts it mid-way
			len = 8'($urandom_range(2, 20));
			send_frame(len, $urandom_range(0, len - 1));
		end else if (pick < 95) begin
			send_release();
		end else begin
			send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
			send_beat(ufd_pkg::FUNC_BYTE, body_byte());
		end
	endtask

	// Result side: random ready with short and long stalls, long open runs,
	// and one long hold-off each time the stimulus raises burst_mode.
	initial begin : result_sink
		int run_left;
		int stall_left;
		bit hold_armed;
		run_left = 0;
		stall_left = 0;
		hold_armed = 1'b0;
		result_chan.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (burst_mode && !hold_armed) begin
				hold_armed = 1'b1;
				stall_left = HOLD_CYCLES;
				run_left = 0;
			end else if (!burst_mode) begin
				hold_armed = 1'b0;
			end
			if (stall_left > 0) begin
				result_chan.ready <= 1'b0;
				stall_left--;
			end else begin
				result_chan.ready <= 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else begin
					run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
						: $urandom_range(0, 6);
					stall_left = pick_gap();
				end
			end
		end
	end

	// Watchdog: end the run if no beat moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((byte_chan.valid && byte_chan.ready) || (result_chan.valid && result_chan.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int frame_no;
		byte_chan.valid <= 1'b0;
		byte_chan.payload <= '0;
		burst_mode <= 1'b0;
		gapless = 1'b0;
		beats_sent = 0;
		tail_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Release with nothing pending, then a byte at position zero.
		send_beat(ufd_pkg::FUNC_RELEASE, 8'hA5);
		send_beat(ufd_pkg::FUNC_BYTE, 8'h00);
		// Double header restarts; a stuffing value below position four is kept.
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_STUFF);
		send_beat(ufd_pkg::FUNC_BYTE, 8'h02);
		// Header byte in the payload, stuffed twice in a row.
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_STUFF);
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_STUFF);
		// Completes the frame; following bytes are held and dropped.
		send_beat(ufd_pkg::FUNC_BYTE, 8'h12);
		send_beat(ufd_pkg::FUNC_BYTE, 8'hAA);
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_RELEASE, 8'hFF);
		// A zero after the header pair sits at position two and is not captured as the length.
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_BYTE, 8'h00);
		send_beat(ufd_pkg::FUNC_RELEASE, 8'h00);
		// Run of headers: restart, restart again, then the largest length.
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_BYTE, ufd_pkg::BYTE_HEADER);
		send_beat(ufd_pkg::FUNC_BYTE, 8'h7F);
		send_beat(ufd_pkg::FUNC_BYTE, 8'hFF);
		send_beat(ufd_pkg::FUNC_BYTE, 8'h80);
		send_release();
		drain();

		// Random part.
		frame_no = 0;
		while (beats_sent - tail_sent < ITEMS) begin
			if (frame_no % 10 == 0)
				gapless = ($urandom_range(0, 3) == 0);
			if (frame_no == 6 || frame_no == 28) begin
				// Keep offering frames while the receiver holds off.
				burst_mode <= 1'b1;
				repeat (3) begin
					send_frame(8'($urandom_range(2, 6)), 6);
					send_release();
				end
				burst_mode <= 1'b0;
			end else if (frame_no == 15) begin
				// Header pair, length byte 0xFF, then a long body with every header byte stuffed.
				send_frame(8'hFF, 0);
				send_body(256, 100);
				send_release();
			end else begin
				random_unit();
			end
			if (frame_no % 25 == 24)
				drain();
			frame_no++;
		end

		// Wait out the last results plus the block latency.
		drain();
		repeat (6) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
